>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds in the same cycle
`define DPSU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define DPSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/dpsu_pkg.sv
// ----------------------------------------------------------------------------
// dpsu_pkg
// types and constants of the dot product and scaled update block
// ----------------------------------------------------------------------------
package dpsu_pkg;

  localparam int ElemW     = 16;
  localparam int LaneW     = 32;
  localparam int LaneCount = 4;
  localparam int LaneIdxW  = $clog2(LaneCount);
  localparam int PosW      = 3;
  localparam int SumW      = LaneW + LaneIdxW;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [LaneW-1:0] lane_t;
  typedef logic        [PosW-1:0]  pos_t;

  localparam lane_t SatMax = {1'b0, {(LaneW-1){1'b1}}};
  localparam lane_t SatMin = {1'b1, {(LaneW-1){1'b0}}};

  // input register contents
  typedef struct packed {
    elem_t weight_elem;
    elem_t sample_elem;
    elem_t update_elem;
    logic  run_end;
  } in_word_t;

  // multiplier stage contents
  typedef struct packed {
    elem_t new_weight;
    lane_t prod;
    logic  run_end;
  } mul_word_t;

  // accumulator stage contents, snap only meaningful on run end
  typedef struct packed {
    elem_t                     new_weight;
    lane_t [LaneCount-1:0]     snap;
    logic                      run_end;
  } acc_word_t;

  // four-way signed add with saturation to 32 bits
  function automatic lane_t sat_total(lane_t [LaneCount-1:0] lanes);
    logic signed [SumW-1:0] sum;
    sum = '0;
    for (int i = 0; i < LaneCount; i++) begin
      sum = sum + SumW'(lanes[i]);
    end
    if (sum > SumW'(SatMax)) begin
      sat_total = SatMax;
    end else if (sum < SumW'(SatMin)) begin
      sat_total = SatMin;
    end else begin
      sat_total = sum[LaneW-1:0];
    end
  endfunction

endpackage

>>> rtl/core/dpsu_in_if.sv
// ----------------------------------------------------------------------------
// dpsu_in_if
// input channel: one element of each vector per word
// ----------------------------------------------------------------------------
interface dpsu_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] weight_elem;
  logic signed [15:0] sample_elem;
  logic signed [15:0] update_elem;
  logic               run_end;

  modport source (output valid, weight_elem, sample_elem, update_elem, run_end,
                  input ready);
  modport sink   (input valid, weight_elem, sample_elem, update_elem, run_end,
                  output ready);
endinterface

>>> rtl/core/dpsu_out_if.sv
// ----------------------------------------------------------------------------
// dpsu_out_if
// result channel: updated weight and, on run end, the dot product
// ----------------------------------------------------------------------------
interface dpsu_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] new_weight;
  logic signed [31:0] dot_total;
  logic               total_valid;

  modport source (output valid, new_weight, dot_total, total_valid, input ready);
  modport sink   (input valid, new_weight, dot_total, total_valid, output ready);
endinterface

>>> rtl/core/dpsu_mul.sv
// ----------------------------------------------------------------------------
// dpsu_mul
// multiplier stage: weight update and weight times sample product
// ----------------------------------------------------------------------------
module dpsu_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  dpsu_pkg::elem_t     scale,
  input  logic                up_valid,
  input  dpsu_pkg::in_word_t  up_word,
  output logic                up_ready,
  output logic                dn_valid,
  output dpsu_pkg::mul_word_t dn_word,
  input  logic                dn_ready
);
  import dpsu_pkg::*;

  logic      valid_r;
  mul_word_t word_r;
  mul_word_t word_nxt;
  lane_t     upd_prod;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    upd_prod            = lane_t'(scale) * lane_t'(up_word.update_elem);
    // only the low half of the scaled term reaches the new weight
    word_nxt.new_weight = up_word.weight_elem + elem_t'(upd_prod[ElemW-1:0]);
    word_nxt.prod       = lane_t'(up_word.weight_elem) * lane_t'(up_word.sample_elem);
    word_nxt.run_end    = up_word.run_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      word_r <= word_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_word  = word_r;

endmodule

>>> rtl/core/dpsu_acc.sv
// ----------------------------------------------------------------------------
// dpsu_acc
// lane accumulator: folds products into four wrapping lane sums
// ----------------------------------------------------------------------------
module dpsu_acc (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  input  dpsu_pkg::mul_word_t up_word,
  output logic                up_ready,
  output logic                dn_valid,
  output dpsu_pkg::acc_word_t dn_word,
  input  logic                dn_ready
);
  import dpsu_pkg::*;

  logic                  valid_r;
  acc_word_t             word_r;
  lane_t [LaneCount-1:0] lanes_r;
  lane_t [LaneCount-1:0] lanes_nxt;
  pos_t                  pos_r;
  logic [LaneIdxW-1:0]   lane_sel;
  logic                  take;

  assign up_ready = !valid_r || dn_ready;
  assign take     = up_ready && up_valid;
  // lane is (position mod 8) / 2
  assign lane_sel = pos_r[PosW-1:1];

  always_comb begin
    for (int i = 0; i < LaneCount; i++) begin
      if (lane_sel == LaneIdxW'(i)) begin
        lanes_nxt[i] = lanes_r[i] + up_word.prod;
      end else begin
        lanes_nxt[i] = lanes_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      lanes_r <= '0;
      pos_r   <= '0;
    end else begin
      if (up_ready) begin
        valid_r <= up_valid;
      end
      if (take) begin
        if (up_word.run_end) begin
          lanes_r <= '0;
          pos_r   <= '0;
        end else begin
          lanes_r <= lanes_nxt;
          pos_r   <= pos_r + pos_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      word_r.new_weight <= up_word.new_weight;
      word_r.snap       <= lanes_nxt;
      word_r.run_end    <= up_word.run_end;
    end
  end

  assign dn_valid = valid_r;
  assign dn_word  = word_r;

endmodule

>>> rtl/core/dpsu_out.sv
// ----------------------------------------------------------------------------
// dpsu_out
// output register: saturated lane total on run end
// ----------------------------------------------------------------------------
module dpsu_out (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  input  dpsu_pkg::acc_word_t up_word,
  output logic                up_ready,
  dpsu_out_if.source          out_ch
);
  import dpsu_pkg::*;

  logic  valid_r;
  elem_t new_weight_r;
  lane_t dot_total_r;
  logic  total_valid_r;
  lane_t dot_total_nxt;

  assign up_ready = !valid_r || out_ch.ready;

  always_comb begin
    if (up_word.run_end) begin
      dot_total_nxt = sat_total(up_word.snap);
    end else begin
      dot_total_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      new_weight_r  <= up_word.new_weight;
      dot_total_r   <= dot_total_nxt;
      total_valid_r <= up_word.run_end;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.new_weight  = new_weight_r;
  assign out_ch.dot_total   = dot_total_r;
  assign out_ch.total_valid = total_valid_r;

endmodule

>>> rtl/core/dot_product_and_scaled_update.sv
// ----------------------------------------------------------------------------
// dot_product_and_scaled_update
// int16 dot product over a run with multiply-add weight update
// ----------------------------------------------------------------------------
// Takes one word per clock while the output is not stalled and returns one
// result per word through four register stages: input register, multiplier
// stage (one 16x16 multiply for the weight update and one for the product),
// lane accumulator, and output register with the saturating four-way add.
// Sustained rate is one word per cycle; a stalled output fills the stages
// before in_ch.ready drops. cfg_wdata sets the update scale and must only be
// written while no word is in flight.
// ----------------------------------------------------------------------------
module dot_product_and_scaled_update (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic signed [15:0] cfg_wdata,
  dpsu_in_if.sink            in_ch,
  dpsu_out_if.source         out_ch
);
  import dpsu_pkg::*;

  elem_t     scale_r;
  logic      in_valid_r;
  in_word_t  in_word_r;
  logic      mul_ready;
  logic      mul_valid;
  mul_word_t mul_word;
  logic      acc_ready;
  logic      acc_valid;
  acc_word_t acc_word;
  logic      out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= '0;
    end else if (cfg_we) begin
      scale_r <= cfg_wdata;
    end
  end

  assign in_ch.ready = !in_valid_r || mul_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_word_r.weight_elem <= in_ch.weight_elem;
      in_word_r.sample_elem <= in_ch.sample_elem;
      in_word_r.update_elem <= in_ch.update_elem;
      in_word_r.run_end     <= in_ch.run_end;
    end
  end

  dpsu_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .scale    (scale_r),
    .up_valid (in_valid_r),
    .up_word  (in_word_r),
    .up_ready (mul_ready),
    .dn_valid (mul_valid),
    .dn_word  (mul_word),
    .dn_ready (acc_ready)
  );

  dpsu_acc u_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mul_valid),
    .up_word  (mul_word),
    .up_ready (acc_ready),
    .dn_valid (acc_valid),
    .dn_word  (acc_word),
    .dn_ready (out_ready)
  );

  dpsu_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (acc_valid),
    .up_word  (acc_word),
    .up_ready (out_ready),
    .out_ch   (out_ch)
  );

endmodule

>>> rtl/core/dpsu_checker.sv
// ----------------------------------------------------------------------------
// dpsu_checker
// port-level checks of the dot product block, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dpsu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_new_weight,
  input logic signed [31:0] out_dot_total,
  input logic               out_total_valid
);

  // a stalled result word stays up
  `DPSU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "out word dropped while stalled")

  // a stalled result word keeps its payload
  `DPSU_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_new_weight) && $stable(out_dot_total) && $stable(out_total_valid), "out word changed while stalled")

  // the total is zero except on run end
  `DPSU_ASSERT(a_total_zero, clk, rst_n, !(out_valid && !out_total_valid) || (out_dot_total == 32'sd0), "dot_total nonzero without total_valid")

  // input backpressure only when every stage is full and the output stalls
  `DPSU_ASSERT(a_bp_cause, clk, rst_n, !(in_valid && !in_ready) || (out_valid && !out_ready), "input stalled without output stall")

endmodule

bind dot_product_and_scaled_update dpsu_checker u_dpsu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_new_weight  (out_ch.new_weight),
  .out_dot_total   (out_ch.dot_total),
  .out_total_valid (out_ch.total_valid)
);
